@@ sv/dbd_pkg.sv @@
// Shared types and constants for the detection box decoder.
// Used by dbd_argmax, dbd_axis_map and detection_box_decode.
`default_nettype none
package dbd_pkg;

	// configuration port
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 24;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_SCORE_THRESHOLD = 3'd0,
		REG_PAD_LEFT        = 3'd1,
		REG_PAD_TOP         = 3'd2,
		REG_INVERSE_SCALE   = 3'd3,
		REG_IMAGE_WIDTH     = 3'd4,
		REG_IMAGE_HEIGHT    = 3'd5,
		REG_CLASS_COUNT     = 3'd6
	} cfg_reg_t;

	// box layout and image limits
	localparam int BOX_FIELDS = 4;
	localparam int MAX_DIM    = 8192;
	localparam int DIM_W      = 14;

	// finished box with its winning class, handed to the mapping stages
	typedef struct packed {
		logic signed [31:0] cx;
		logic signed [31:0] cy;
		logic signed [31:0] w;
		logic signed [31:0] h;
		logic        [7:0]  best_class;
		logic        [30:0] best_score;
	} box_item_t;

endpackage
`default_nettype wire

@@ sv/dbd_argmax.sv @@
// Element sequencer: stores the four box values and tracks the class argmax.
// Depends on dbd_pkg; loads a finished box into the first pipeline stage.
`default_nettype none
module dbd_argmax import dbd_pkg::*; #(
	parameter int MAX_CLASSES = 128
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               accept,
	input  wire logic signed [31:0] element,
	input  wire logic        [16:0] score_threshold,
	input  wire logic        [7:0]  class_count,
	output logic                    emit,
	output box_item_t               item_s1
);

	localparam int IDX_W = $clog2(MAX_CLASSES + BOX_FIELDS);
	localparam int CLS_W = $clog2(MAX_CLASSES + 1);
	localparam int CNT_W = 10;

	logic        [IDX_W-1:0] idx_q;
	logic signed [31:0]      max_q;
	logic        [CLS_W-1:0] cls_q;
	logic                    has_q;
	logic signed [31:0]      box_q [BOX_FIELDS];

	logic        [CNT_W-1:0] nc;
	logic        [CNT_W-1:0] last_pos;
	logic                    is_last;
	logic                    is_box;
	logic                    gt;
	logic signed [31:0]      max_n;
	logic        [CLS_W-1:0] cls_n;
	logic                    has_n;
	logic        [IDX_W-1:0] cidx;
	logic        [CLS_W+7:0] cls_ext;

	// limit the class count to 1..MAX_CLASSES and find the last position
	always_comb begin
		if (class_count == 8'd0) begin
			nc = CNT_W'(1);
		end else if (CNT_W'(class_count) > CNT_W'(MAX_CLASSES)) begin
			nc = CNT_W'(MAX_CLASSES);
		end else begin
			nc = CNT_W'(class_count);
		end
		last_pos = CNT_W'(BOX_FIELDS - 1) + nc;
		is_last  = CNT_W'(idx_q) >= last_pos;
		is_box   = idx_q < IDX_W'(BOX_FIELDS);
	end

	// strict greater test, first maximum wins
	always_comb begin
		cidx  = idx_q - IDX_W'(BOX_FIELDS);
		gt    = !is_box && (element > max_q);
		max_n = gt ? element : max_q;
		cls_n = gt ? cidx[CLS_W-1:0] : cls_q;
		has_n = has_q | gt;
		emit  = is_last && ($unsigned(max_n) >= {15'd0, score_threshold});
		cls_ext = {8'd0, cls_n};
	end

	// advance the row position and the running maximum
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q <= '0;
			max_q <= '0;
			cls_q <= '0;
			has_q <= 1'b0;
		end else if (accept) begin
			if (is_last) begin
				idx_q <= '0;
				max_q <= '0;
				cls_q <= '0;
				has_q <= 1'b0;
			end else begin
				idx_q <= idx_q + IDX_W'(1);
				max_q <= max_n;
				cls_q <= cls_n;
				has_q <= has_n;
			end
		end
	end

	// hold the box values
	always_ff @(posedge clk) begin
		if (accept && is_box) begin
			box_q[idx_q[1:0]] <= element;
		end
	end

	// load the finished box
	always_ff @(posedge clk) begin
		if (accept && emit) begin
			item_s1.cx         <= box_q[0];
			item_s1.cy         <= box_q[1];
			item_s1.w          <= box_q[2];
			item_s1.h          <= box_q[3];
			item_s1.best_class <= has_n ? cls_ext[7:0] : 8'hFF;
			item_s1.best_score <= max_n[30:0];
		end
	end

endmodule
`default_nettype wire

@@ sv/dbd_axis_map.sv @@
// One axis of the letterbox inverse: pad removal, scaling, truncation, clamp.
// Depends on dbd_pkg; two pipeline stages, enables come from the top level.
`default_nettype none
module dbd_axis_map import dbd_pkg::*; (
	input  wire logic               clk,
	input  wire logic               en_s2,
	input  wire logic               en_s3,
	input  wire logic signed [31:0] center,
	input  wire logic signed [31:0] extent,
	input  wire logic        [11:0] pad,
	input  wire logic        [23:0] inv_scale,
	input  wire logic [DIM_W-1:0]   limit,
	output logic             [12:0] edge_px,
	output logic signed      [16:0] size_px
);

	logic signed [58:0] cpad_ext;
	logic signed [58:0] inv_c;
	logic signed [56:0] ext_ext;
	logic signed [56:0] inv_e;
	logic signed [58:0] c2_s2;
	logic signed [56:0] w2_s2;
	logic signed [60:0] twice;
	logic signed [27:0] e_raw;
	logic signed [24:0] s_raw;
	logic signed [27:0] e_s3;
	logic signed [24:0] s_s3;
	logic signed [27:0] lim_s;
	logic signed [27:0] e_cl;
	logic signed [27:0] rem;
	logic signed [27:0] s_cl;
	logic signed [27:0] s_ext;

	// center minus pad and both scaled products
	always_comb begin
		cpad_ext = {{27{center[31]}}, center} - $signed({31'd0, pad, 16'd0});
		inv_c    = $signed({35'd0, inv_scale});
		ext_ext  = {{25{extent[31]}}, extent};
		inv_e    = $signed({33'd0, inv_scale});
	end

	always_ff @(posedge clk) begin
		if (en_s2) begin
			c2_s2 <= cpad_ext * inv_c;
			w2_s2 <= ext_ext * inv_e;
		end
	end

	// halve-and-shift with truncation toward zero
	always_comb begin
		twice = {{1{c2_s2[58]}}, c2_s2, 1'b0} - {{4{w2_s2[56]}}, w2_s2};
		e_raw = twice[60:33] + 28'(twice[60] && (twice[32:0] != '0));
		s_raw = w2_s2[56:32] + 25'(w2_s2[56] && (w2_s2[31:0] != '0));
	end

	always_ff @(posedge clk) begin
		if (en_s3) begin
			e_s3 <= e_raw;
			s_s3 <= s_raw;
		end
	end

	// clamp the edge, then cap the size by the remaining extent and floor it at -65536
	always_comb begin
		lim_s = $signed({14'd0, limit});
		if (e_s3 > lim_s - 28'sd1) begin
			e_cl = lim_s - 28'sd1;
		end else if (e_s3 < 28'sd0) begin
			e_cl = '0;
		end else begin
			e_cl = e_s3;
		end
		rem   = lim_s - e_cl;
		s_ext = {{3{s_s3[24]}}, s_s3};
		if (s_ext > rem) begin
			s_cl = rem;
		end else if (s_ext < -28'sd65536) begin
			s_cl = -28'sd65536;
		end else begin
			s_cl = s_ext;
		end
		edge_px = e_cl[12:0];
		size_px = s_cl[16:0];
	end

endmodule
`default_nettype wire

@@ sv/detection_box_decode.sv @@
// Detection box decoder: one row element per cycle, one box per passing row.
// Path: a box passes item_s1, the s2 and s3 mapping stages and the output register.
// Throughput: one element per cycle; stages only stall while the output register is held.
// Reset: arst_n clears the row position, running maximum, valid bits and config registers
// to their defaults (threshold 16384, scale 65536, image 640x640, 80 classes).
// Depends on dbd_pkg, dbd_argmax and dbd_axis_map.
`default_nettype none
module detection_box_decode import dbd_pkg::*; #(
	parameter int MAX_CLASSES = 128
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  cfg_we,
	input  wire logic [CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [CFG_DATA_W-1:0] cfg_data,
	input  wire logic                  s_axis_tvalid,
	output logic                       s_axis_tready,
	// [31:0] element_value
	input  wire logic [31:0]           s_axis_tdata,
	output logic                       m_axis_tvalid,
	input  wire logic                  m_axis_tready,
	// [12:0] box_left, [25:13] box_top, [42:26] box_width, [59:43] box_height,
	// [67:60] best_class, [98:68] best_score, [103:99] zero
	output logic [103:0]               m_axis_tdata
);

	logic [16:0]      thr_q;
	logic [11:0]      pad_l_q;
	logic [11:0]      pad_t_q;
	logic [23:0]      inv_q;
	logic [DIM_W-1:0] img_w_q;
	logic [DIM_W-1:0] img_h_q;
	logic [7:0]       cls_cnt_q;

	logic [DIM_W-1:0] lim_w;
	logic [DIM_W-1:0] lim_h;

	logic      accept;
	logic      emit;
	box_item_t item_s1;
	logic      v_s1;
	logic      v_s2;
	logic      v_s3;
	logic      out_v_q;
	logic      en_s2;
	logic      en_s3;
	logic      en_out;
	logic [7:0]  cls_s2;
	logic [30:0] score_s2;
	logic [7:0]  cls_s3;
	logic [30:0] score_s3;

	logic        [12:0] left_px;
	logic        [12:0] top_px;
	logic signed [16:0] wid_px;
	logic signed [16:0] hgt_px;

	// configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thr_q     <= 17'd16384;
			pad_l_q   <= '0;
			pad_t_q   <= '0;
			inv_q     <= 24'd65536;
			img_w_q   <= DIM_W'(640);
			img_h_q   <= DIM_W'(640);
			cls_cnt_q <= 8'd80;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_SCORE_THRESHOLD: thr_q     <= cfg_data[16:0];
				REG_PAD_LEFT:        pad_l_q   <= cfg_data[11:0];
				REG_PAD_TOP:         pad_t_q   <= cfg_data[11:0];
				REG_INVERSE_SCALE:   inv_q     <= cfg_data[23:0];
				REG_IMAGE_WIDTH:     img_w_q   <= cfg_data[DIM_W-1:0];
				REG_IMAGE_HEIGHT:    img_h_q   <= cfg_data[DIM_W-1:0];
				REG_CLASS_COUNT:     cls_cnt_q <= cfg_data[7:0];
				default: ;
			endcase
		end
	end

	// image size limited to 1..MAX_DIM
	function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] d);
		logic [DIM_W-1:0] r;
		if (d == '0) begin
			r = DIM_W'(1);
		end else if (d > DIM_W'(MAX_DIM)) begin
			r = DIM_W'(MAX_DIM);
		end else begin
			r = d;
		end
		return r;
	endfunction

	assign lim_w = clamp_dim(img_w_q);
	assign lim_h = clamp_dim(img_h_q);

	// stage enables: a stage moves when it is empty or the next one moves
	assign en_out        = !out_v_q || m_axis_tready;
	assign en_s3         = !v_s3 || en_out;
	assign en_s2         = !v_s2 || en_s3;
	assign s_axis_tready = !v_s1 || en_s2;
	assign accept        = s_axis_tvalid && s_axis_tready;

	dbd_argmax #(
		.MAX_CLASSES(MAX_CLASSES)
	) u_argmax (
		.clk             (clk),
		.arst_n          (arst_n),
		.accept          (accept),
		.element         ($signed(s_axis_tdata)),
		.score_threshold (thr_q),
		.class_count     (cls_cnt_q),
		.emit            (emit),
		.item_s1         (item_s1)
	);

	dbd_axis_map u_map_x (
		.clk       (clk),
		.en_s2     (en_s2),
		.en_s3     (en_s3),
		.center    (item_s1.cx),
		.extent    (item_s1.w),
		.pad       (pad_l_q),
		.inv_scale (inv_q),
		.limit     (lim_w),
		.edge_px   (left_px),
		.size_px   (wid_px)
	);

	dbd_axis_map u_map_y (
		.clk       (clk),
		.en_s2     (en_s2),
		.en_s3     (en_s3),
		.center    (item_s1.cy),
		.extent    (item_s1.h),
		.pad       (pad_t_q),
		.inv_scale (inv_q),
		.limit     (lim_h),
		.edge_px   (top_px),
		.size_px   (hgt_px)
	);

	// advance the valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1    <= 1'b0;
			v_s2    <= 1'b0;
			v_s3    <= 1'b0;
			out_v_q <= 1'b0;
		end else begin
			if (s_axis_tready) begin
				v_s1 <= accept && emit;
			end
			if (en_s2) begin
				v_s2 <= v_s1;
			end
			if (en_s3) begin
				v_s3 <= v_s2;
			end
			if (en_out) begin
				out_v_q <= v_s3;
			end
		end
	end

	// carry class and score alongside the mapping stages
	always_ff @(posedge clk) begin
		if (en_s2) begin
			cls_s2   <= item_s1.best_class;
			score_s2 <= item_s1.best_score;
		end
		if (en_s3) begin
			cls_s3   <= cls_s2;
			score_s3 <= score_s2;
		end
		if (en_out) begin
			m_axis_tdata <= {5'd0, score_s3, cls_s3, hgt_px, wid_px, top_px, left_px};
		end
	end

	assign m_axis_tvalid = out_v_q;

endmodule
`default_nettype wire
